// File: rtl/core/nks_pkg.sv
// Package for the nearest-K selector: widths, constants, register indexes
// and the packed types that travel between the modules.
// No dependencies.
package nks_pkg;

    // List and emission sizes.
    localparam int KEEP_COUNT  = 16;
    localparam int MAX_EMIT    = 16;
    localparam int EMIT_W      = $clog2(MAX_EMIT);

    // Field widths.
    localparam int POS_W       = 24;
    localparam int MAG_W       = 24;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int DIST_W      = SQ_W + 2;
    localparam int OUT_DIST_W  = 52;
    localparam int IDX_W       = 16;
    localparam int SEL_W       = 5;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;

    localparam logic [IDX_W-1:0]      EMPTY_INDEX = '1;
    localparam logic [OUT_DIST_W-1:0] DIST_MAX    = '1;

    // Register indexes (byte address divided by eight).
    localparam logic [2:0] REG_SOURCE_X     = 3'd0;
    localparam logic [2:0] REG_SOURCE_Y     = 3'd1;
    localparam logic [2:0] REG_SOURCE_Z     = 3'd2;
    localparam logic [2:0] REG_MAX_DIST_SQ  = 3'd3;
    localparam logic [2:0] REG_SELECT_COUNT = 3'd4;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    batch_end;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]      point_index;
        logic                  found;
        logic [OUT_DIST_W-1:0] dist_sq;
        logic                  run_end;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0] source_x;
        logic signed [POS_W-1:0] source_y;
        logic signed [POS_W-1:0] source_z;
        logic [OUT_DIST_W-1:0]   max_dist_sq;
        logic [SEL_W-1:0]        select_count;
    } t_cfg;

    // One classified point handed from the front to the back.
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] sq_dist;
        logic              keep;
        logic              last;
    } t_work;

endpackage

// File: rtl/core/nks_front.sv
// Front part of the nearest-K selector: accepts points, numbers them and
// computes the squared distance in four stages. Depends on nks_pkg.
module nks_front
    import nks_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_push,
    output t_work    o_work,
    input  logic     i_full
);

    // Magnitude of the difference of two Q12.12 coordinates.
    function automatic logic [MAG_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic [POS_W:0] d;
        logic [POS_W:0] m;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        m = d[POS_W] ? (~d + 1'b1) : d;
        return m[MAG_W-1:0];
    endfunction

    logic              r_v1, r_v2, r_v3, r_v4;
    logic              en1, en2, en3, en4;
    logic              accept;
    logic [IDX_W-1:0]  r_count;

    logic [MAG_W-1:0]  r1_mag_x, r1_mag_y, r1_mag_z;
    logic [IDX_W-1:0]  r1_idx, r2_idx, r3_idx;
    logic              r1_ok, r2_ok, r3_ok;
    logic              r1_last, r2_last, r3_last;
    logic [SQ_W-1:0]   r2_sq_x, r2_sq_y, r2_sq_z;
    logic [DIST_W-1:0] r3_dist;
    t_work             r4_work;

    // Stage enables: a stage loads when it is empty or its content moves on.
    assign en4     = !r_v4 || !i_full;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign accept  = i_valid && en1;
    assign o_push  = r_v4 && !i_full;
    assign o_work  = r4_work;

    // Stage valid bits and the arrival counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_count <= '0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (accept) begin
                if (i_item.batch_end) begin
                    r_count <= '0;
                end else if (r_count != EMPTY_INDEX) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Datapath: differences, squares, sum, limit compare.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mag_x <= abs_diff(i_item.pos_x, i_cfg.source_x);
            r1_mag_y <= abs_diff(i_item.pos_y, i_cfg.source_y);
            r1_mag_z <= abs_diff(i_item.pos_z, i_cfg.source_z);
            r1_idx   <= r_count;
            r1_ok    <= (r_count != EMPTY_INDEX);
            r1_last  <= i_item.batch_end;
        end
        if (en2) begin
            r2_sq_x <= r1_mag_x * r1_mag_x;
            r2_sq_y <= r1_mag_y * r1_mag_y;
            r2_sq_z <= r1_mag_z * r1_mag_z;
            r2_idx  <= r1_idx;
            r2_ok   <= r1_ok;
            r2_last <= r1_last;
        end
        if (en3) begin
            r3_dist <= DIST_W'(r2_sq_x) + DIST_W'(r2_sq_y) + DIST_W'(r2_sq_z);
            r3_idx  <= r2_idx;
            r3_ok   <= r2_ok;
            r3_last <= r2_last;
        end
        if (en4) begin
            r4_work.index   <= r3_idx;
            r4_work.sq_dist <= r3_dist;
            r4_work.keep    <= r3_ok && (OUT_DIST_W'(r3_dist) <= i_cfg.max_dist_sq);
            r4_work.last    <= r3_last;
        end
    end

endmodule

// File: rtl/core/nks_queue.sv
// Short queue between the front and back parts of the nearest-K selector.
// Depends on nks_pkg.
module nks_queue
    import nks_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output t_work o_work,
    output logic  o_full,
    output logic  o_empty
);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_work;
    end

endmodule

// File: rtl/core/nks_back.sv
// Back part of the nearest-K selector: keeps the sorted list of the closest
// points and emits the selected slots at batch end. Depends on nks_pkg.
module nks_back
    import nks_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SEL_W-1:0] i_select_count,
    input  logic             i_empty,
    input  t_work            i_work,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_item
);

    typedef enum logic {
        S_RUN,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [EMIT_W-1:0]  r_k;
    logic [EMIT_W-1:0]  r_last_k;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [KEEP_COUNT-1:0] r_used;
    logic [IDX_W-1:0]      r_idx  [KEEP_COUNT];
    logic [DIST_W-1:0]     r_dist [KEEP_COUNT];

    logic [KEEP_COUNT-1:0] ge;
    logic [KEEP_COUNT-1:0] ge_prev;
    logic [IDX_W-1:0]      up_idx  [KEEP_COUNT];
    logic [DIST_W-1:0]     up_dist [KEEP_COUNT];
    logic                  insert;
    logic                  load;
    logic                  clear;
    logic                  sel_hit;
    logic [IDX_W-1:0]      sel_idx;
    logic [DIST_W-1:0]     sel_dist;
    logic [EMIT_W-1:0]     n_last_k;

    assign o_pop   = (r_state == S_RUN) && !i_empty;
    assign insert  = o_pop && i_work.keep;
    assign load    = (r_state == S_EMIT) && (!r_out_valid || i_ready);
    assign clear   = load && (r_k == r_last_k);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // Slot compare: a slot at or after the insertion point is free or not closer.
    // The list is sorted and filled from the front, so ge is a run of ones at the top.
    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            ge[i] = !r_used[i] || (r_dist[i] >= i_work.sq_dist);
        end
        ge_prev    = ge << 1;
        up_idx[0]  = r_idx[0];
        up_dist[0] = r_dist[0];
        for (int i = 1; i < KEEP_COUNT; i++) begin
            up_idx[i]  = r_idx[i - 1];
            up_dist[i] = r_dist[i - 1];
        end
    end

    // Slot read for emission.
    always_comb begin
        sel_hit  = 1'b0;
        sel_idx  = EMPTY_INDEX;
        sel_dist = '0;
        for (int i = 0; i < KEEP_COUNT; i++) begin
            if (i == int'(r_k)) begin
                sel_hit  = r_used[i];
                sel_idx  = r_idx[i];
                sel_dist = r_dist[i];
            end
        end
    end

    // Number of results for this batch, less one, with select_count clamped.
    always_comb begin
        if (i_select_count == '0) begin
            n_last_k = '0;
        end else if (i_select_count >= SEL_W'(MAX_EMIT)) begin
            n_last_k = EMIT_W'(MAX_EMIT - 1);
        end else begin
            n_last_k = EMIT_W'(i_select_count - 1'b1);
        end
    end

    // Slot valid bits: an insertion adds one used slot at the front of the
    // free run, cleared after the last result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (clear) begin
            r_used <= '0;
        end else if (insert) begin
            r_used <= {r_used[KEEP_COUNT-2:0], 1'b1};
        end
    end

    // Slot contents: shift down behind the insertion point.
    always_ff @(posedge i_clk) begin
        if (insert) begin
            for (int i = 0; i < KEEP_COUNT; i++) begin
                if (ge[i]) begin
                    r_idx[i]  <= ge_prev[i] ? up_idx[i]  : i_work.index;
                    r_dist[i] <= ge_prev[i] ? up_dist[i] : i_work.sq_dist;
                end
            end
        end
    end

    // Control state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_k         <= '0;
            r_last_k    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_RUN: begin
                    if (o_valid && i_ready) r_out_valid <= 1'b0;
                    if (o_pop && i_work.last) begin
                        r_state  <= S_EMIT;
                        r_k      <= '0;
                        r_last_k <= n_last_k;
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_out_valid       <= 1'b1;
                        r_out.point_index <= sel_hit ? sel_idx : EMPTY_INDEX;
                        r_out.found       <= sel_hit;
                        r_out.dist_sq     <= sel_hit ? OUT_DIST_W'(sel_dist) : DIST_MAX;
                        r_out.run_end     <= (r_k == r_last_k);
                        if (r_k == r_last_k) begin
                            r_state <= S_RUN;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    // The list is filled from the front: no used slot follows a free one.
    a_used_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ge_prev == (ge << 1)) |-> ((r_used & ~(r_used << 1) & ~KEEP_COUNT'(1)) == '0))
        else $error("slot list has a hole");

    // No point is taken from the queue while results are being emitted.
    a_no_pop_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !o_pop)
        else $error("queue popped during emission");

    // After the last result is loaded the list is empty and work resumes.
    a_clear_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (r_used == '0 && r_state == S_RUN && r_out.run_end))
        else $error("list not cleared after batch");

endmodule

// File: rtl/core/nearest_k_selector.sv
// Top level of the nearest-K selector: configuration registers and the
// front, queue and back parts. Depends on nks_pkg, nks_front, nks_queue, nks_back.
//
// Points enter on the input channel (i_in_valid, o_in_ready, i_in_data), one
// request per cycle while o_in_ready is high. Each is given its arrival index
// and its squared distance to the configured source point. Kept points enter
// a sorted list of the sixteen closest. A point marked batch_end makes the
// block send select_count results (one if it is zero, at most sixteen) on the
// output channel (o_out_valid, i_out_ready, o_out_data), the last one flagged
// run_end; the list and the index counter then start over. The distance
// pipeline is four stages; a batch's results follow its last point, one per
// cycle while the receiver is ready. Input throughput is one point per cycle, set
// by the parallel list insertion. While results are emitted the list takes no
// points; a four-entry queue and the pipeline keep taking input until full.
// A stalled receiver holds the output register and, through it, the list.
// Reset empties the list, zeroes the index and loads the register defaults.
// Registers are written over the APB port at byte address 8 * index.
module nearest_k_selector
    import nks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg        r_cfg;
    logic        cfg_write;
    logic [2:0]  reg_index;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_work       front_work;
    t_work       head_work;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[APB_ADDR_W-1:3];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_x     <= '0;
            r_cfg.source_y     <= '0;
            r_cfg.source_z     <= '0;
            r_cfg.max_dist_sq  <= '0;
            r_cfg.select_count <= SEL_W'(1);
        end else if (cfg_write) begin
            case (reg_index)
                REG_SOURCE_X:     r_cfg.source_x     <= pwdata[POS_W-1:0];
                REG_SOURCE_Y:     r_cfg.source_y     <= pwdata[POS_W-1:0];
                REG_SOURCE_Z:     r_cfg.source_z     <= pwdata[POS_W-1:0];
                REG_MAX_DIST_SQ:  r_cfg.max_dist_sq  <= pwdata[OUT_DIST_W-1:0];
                REG_SELECT_COUNT: r_cfg.select_count <= pwdata[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_index)
            REG_SOURCE_X:     prdata = APB_DATA_W'(unsigned'(r_cfg.source_x));
            REG_SOURCE_Y:     prdata = APB_DATA_W'(unsigned'(r_cfg.source_y));
            REG_SOURCE_Z:     prdata = APB_DATA_W'(unsigned'(r_cfg.source_z));
            REG_MAX_DIST_SQ:  prdata = APB_DATA_W'(r_cfg.max_dist_sq);
            REG_SELECT_COUNT: prdata = APB_DATA_W'(r_cfg.select_count);
            default:          prdata = '0;
        endcase
    end

    nks_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_push  (push),
        .o_work  (front_work),
        .i_full  (full)
    );

    nks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_work  (head_work),
        .o_full  (full),
        .o_empty (empty)
    );

    nks_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_select_count (r_cfg.select_count),
        .i_empty        (empty),
        .i_work         (head_work),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_item         (o_out_data)
    );

endmodule

// File: bench/nks_result_checker.sv
// Result checker for nearest_k_selector: follows APB writes, predicts the
// selection for every accepted point request and compares the emitted slots.
// Depends on nks_pkg only.
module nks_result_checker
    import nks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    logic signed [POS_W-1:0] src_x;
    logic signed [POS_W-1:0] src_y;
    logic signed [POS_W-1:0] src_z;
    logic [OUT_DIST_W-1:0]   dist_limit;
    logic [SEL_W-1:0]        emit_count;

    // Sorted list of the closest points, nearest first.
    logic [IDX_W-1:0]      near_index [KEEP_COUNT];
    logic [OUT_DIST_W-1:0] near_sq    [KEEP_COUNT];
    logic                  near_used  [KEEP_COUNT];
    int unsigned           arrivals;

    t_out_item expected_slots [$];
    int        errors = 0;
    int        results_seen = 0;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic void clear_list();
        for (int i = 0; i < KEEP_COUNT; i++) begin
            near_index[i] = EMPTY_INDEX;
            near_sq[i]    = DIST_MAX;
            near_used[i]  = 1'b0;
        end
        arrivals = 0;
    endfunction

    function automatic void write_setting(input logic [2:0] idx,
                                          input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_SOURCE_X:     src_x      = value[POS_W-1:0];
            REG_SOURCE_Y:     src_y      = value[POS_W-1:0];
            REG_SOURCE_Z:     src_z      = value[POS_W-1:0];
            REG_MAX_DIST_SQ:  dist_limit = value[OUT_DIST_W-1:0];
            REG_SELECT_COUNT: emit_count = value[SEL_W-1:0];
            default: ;
        endcase
    endfunction

    // Exact squared distance; the sum of three 25-bit squares stays below 2^50.
    function automatic logic [OUT_DIST_W-1:0] squared_distance(input t_in_item pt);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(pt.pos_x)) - longint'(src_x);
        dy = longint'($signed(pt.pos_y)) - longint'(src_y);
        dz = longint'($signed(pt.pos_z)) - longint'(src_z);
        return OUT_DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // A point goes ahead of the first free slot or of the first slot that is
    // not closer, so a newer point wins a tie. The farthest one falls off.
    function automatic void sort_in_point(input logic [IDX_W-1:0] idx,
                                          input logic [OUT_DIST_W-1:0] sq);
        int slot;
        slot = KEEP_COUNT;
        for (int i = 0; i < KEEP_COUNT; i++)
            if (slot == KEEP_COUNT && (!near_used[i] || near_sq[i] >= sq))
                slot = i;
        if (slot == KEEP_COUNT)
            return;
        for (int i = KEEP_COUNT - 1; i > slot; i--) begin
            near_index[i] = near_index[i-1];
            near_sq[i]    = near_sq[i-1];
            near_used[i]  = near_used[i-1];
        end
        near_index[slot] = idx;
        near_sq[slot]    = sq;
        near_used[slot]  = 1'b1;
    endfunction

    // One accepted point request; the batch end queues the selected slots.
    function automatic void take_point(input t_in_item pt);
        logic [OUT_DIST_W-1:0] sq;
        t_out_item             slot_res;
        int                    n;
        if (arrivals < EMPTY_INDEX) begin
            sq = squared_distance(pt);
            if (sq <= dist_limit)
                sort_in_point(IDX_W'(arrivals), sq);
            arrivals++;
        end
        if (!pt.batch_end)
            return;
        n = (emit_count == 0) ? 1 : (emit_count > MAX_EMIT) ? MAX_EMIT : int'(emit_count);
        for (int k = 0; k < n; k++) begin
            if (k < KEEP_COUNT && near_used[k]) begin
                slot_res.point_index = near_index[k];
                slot_res.found       = 1'b1;
                slot_res.dist_sq     = near_sq[k];
            end else begin
                slot_res.point_index = EMPTY_INDEX;
                slot_res.found       = 1'b0;
                slot_res.dist_sq     = DIST_MAX;
            end
            slot_res.run_end = (k == n - 1);
            expected_slots = {expected_slots, slot_res};
        end
        clear_list();
    endfunction

    // Every emitted slot is matched against the oldest expected one.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_slots.size() == 0) begin
            report_mismatch($sformatf("unexpected result, point_index %0d",
                                      got.point_index));
        end else begin
            want = expected_slots.pop_front();
            check_field("point_index", 64'(got.point_index), 64'(want.point_index));
            check_field("found", 64'(got.found), 64'(want.found));
            check_field("dist_sq", 64'(got.dist_sq), 64'(want.dist_sq));
            check_field("run_end", 64'(got.run_end), 64'(want.run_end));
        end
    endtask

    // Watch the register port and both channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_x      = '0;
            src_y      = '0;
            src_z      = '0;
            dist_limit = '0;
            emit_count = SEL_W'(1);
            clear_list();
            expected_slots.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                write_setting(paddr[APB_ADDR_W-1:3], pwdata);
            if (i_out_valid && i_out_ready)
                check_result(i_out_data);
            if (i_in_valid && i_in_ready)
                take_point(i_in_data);
        end
        o_pending <= expected_slots.size();
        o_errors  <= errors;
    end

endmodule

// File: bench/tb_nearest_k_selector.sv
// Testbench top for nearest_k_selector: clock, reset, point requests, receiver
// stalls and register set-up over APB. Depends on nks_pkg, the block and
// nks_result_checker, which predicts and compares every result.
module tb_nearest_k_selector;
    timeunit 1ns;
    timeprecision 1ps;
    import nks_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 420;
    localparam int PHASE_ITEMS   = 70;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 12_000_000;

    localparam logic signed [POS_W-1:0] POS_HIGH = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_LOW  = 24'sh800000;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_CADENCE} t_rx_mode;
    typedef enum int {PT_NEAR, PT_REPEAT, PT_SOURCE, PT_WILD} t_point_kind;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    pending;

    // Stimulus state: current source point, pacing and the receiver hold-off.
    logic signed [POS_W-1:0] stim_src_x = '0;
    logic signed [POS_W-1:0] stim_src_y = '0;
    logic signed [POS_W-1:0] stim_src_z = '0;
    t_in_item                prev_point = '0;
    bit                      gapless    = 1'b0;
    int                      burst_left = 0;
    int                      hold_asks  = 0;

    nearest_k_selector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    nks_result_checker result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Clock generation.
    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Receiver: changing stall patterns, and a long hold-off when asked for.
    initial begin : receiver
        t_rx_mode mode;
        int       left;
        int       served;
        mode   = RX_ALWAYS;
        left   = 0;
        served = 0;
        forever begin
            @(posedge clk);
            if (served != hold_asks) begin
                served = hold_asks;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= (left % 3 != 0);
                endcase
            end
        end
    end

    // Hard limit on the whole run.
    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("== FAIL ==");
        $finish;
    end

    // One APB write; psel stays up so that writes can follow back to back.
    task automatic write_register(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_search(input logic signed [POS_W-1:0] sx, sy, sz,
                              input logic [OUT_DIST_W-1:0] limit,
                              input logic [SEL_W-1:0] count);
        stim_src_x = sx;
        stim_src_y = sy;
        stim_src_z = sz;
        write_register(REG_SOURCE_X, APB_DATA_W'(sx));
        write_register(REG_SOURCE_Y, APB_DATA_W'(sy));
        write_register(REG_SOURCE_Z, APB_DATA_W'(sz));
        write_register(REG_MAX_DIST_SQ, APB_DATA_W'(limit));
        write_register(REG_SELECT_COUNT, APB_DATA_W'(count));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one point request and hold it until accepted; bursts end in gaps unless gapless is set.
    task automatic offer_point(input t_in_item pt);
        int gap;
        in_valid <= 1'b1;
        in_data  <= pt;
        do @(posedge clk); while (!in_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            if (!gapless) begin
                gap = $urandom_range(1, 10);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Pause the sender until every expected result has arrived, then settle.
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_in_item make_point(input logic signed [POS_W-1:0] x, y, z,
                                            input logic is_last);
        t_in_item pt;
        pt.pos_x     = x;
        pt.pos_y     = y;
        pt.pos_z     = z;
        pt.batch_end = is_last;
        return pt;
    endfunction

    function automatic t_in_item wild_point();
        return make_point(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), 1'b0);
    endfunction

    // Coordinate within 2^scale of c, clipped to the Q12.12 range.
    function automatic logic signed [POS_W-1:0] near_coord(input logic signed [POS_W-1:0] c,
                                                          input int scale);
        longint v;
        v = longint'(c) + longint'($urandom_range(0, (1 << (scale + 1)) - 1))
            - (longint'(1) << scale);
        if (v > longint'(POS_HIGH))
            v = longint'(POS_HIGH);
        if (v < longint'(POS_LOW))
            v = longint'(POS_LOW);
        return POS_W'(v);
    endfunction

    // Mostly points around the source, plus repeats for ties, exact hits
    // on the source and points anywhere in the range.
    function automatic t_in_item pick_point(input int scale);
        t_point_kind kind;
        t_in_item    pt;
        int          r;
        r = $urandom_range(0, 9);
        kind = (r == 0) ? PT_REPEAT : (r == 1) ? PT_SOURCE : (r == 2) ? PT_WILD : PT_NEAR;
        case (kind)
            PT_REPEAT: pt = prev_point;
            PT_SOURCE: pt = make_point(stim_src_x, stim_src_y, stim_src_z, 1'b0);
            PT_WILD:   pt = wild_point();
            default:   pt = make_point(near_coord(stim_src_x, scale),
                                       near_coord(stim_src_y, scale),
                                       near_coord(stim_src_z, scale), 1'b0);
        endcase
        pt.batch_end = 1'b0;
        prev_point   = pt;
        return pt;
    endfunction

    // Directed batches: limit edge, ties, a full list and select count edges.
    task automatic run_directed();
        t_in_item pt;
        t_in_item twin;
        // Limit of 3.0^2: one point exactly on it, one just past it.
        set_search('0, '0, '0, 52'd150994944, 5'd16);
        offer_point(make_point(24'sd12288, '0, '0, 1'b0));
        offer_point(make_point(24'sd12289, '0, '0, 1'b0));
        offer_point(make_point('0, '0, '0, 1'b0));
        offer_point(make_point('0, '0, '0, 1'b0));
        offer_point(make_point('0, -24'sd12288, '0, 1'b0));
        offer_point(make_point(POS_HIGH, POS_LOW, POS_HIGH, 1'b0));
        offer_point(make_point(POS_LOW, POS_HIGH, POS_LOW, 1'b0));
        offer_point(make_point(24'sd1, -24'sd1, 24'sd1, 1'b1));
        drain_results();

        // Source at a corner, no limit, more points than the list holds and
        // a select count above the maximum.
        set_search(POS_LOW, POS_HIGH, POS_LOW, DIST_MAX, 5'd17);
        twin = '0;
        offer_point(make_point(POS_HIGH, POS_LOW, POS_HIGH, 1'b0));
        for (int i = 0; i < 15; i++) begin
            pt = wild_point();
            if (i == 4)
                twin = pt;
            offer_point(pt);
        end
        offer_point(twin);
        offer_point(make_point(POS_LOW, POS_HIGH, POS_LOW, 1'b1));
        drain_results();

        // Zero limit and a select count of zero: one hit, then an empty slot.
        set_search(POS_LOW, POS_HIGH, POS_LOW, '0, '0);
        offer_point(make_point(POS_LOW, POS_HIGH, POS_LOW, 1'b1));
        offer_point(make_point('0, '0, '0, 1'b1));
        drain_results();
    endtask

    // One random setting followed by batches of random points.
    task automatic run_random_phase(input int budget, input bit pressure, output int sent);
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] sz;
        logic [OUT_DIST_W-1:0]   limit;
        logic [SEL_W-1:0]        count;
        t_in_item                pt;
        int                      scale;
        int                      batch_len;
        int                      batch_no;
        scale = $urandom_range(0, 22);
        case ($urandom_range(0, 3))
            0: begin
                sx = '0;
                sy = '0;
                sz = '0;
            end
            1: begin
                sx = $urandom_range(0, 1) ? POS_HIGH : POS_LOW;
                sy = $urandom_range(0, 1) ? POS_HIGH : POS_LOW;
                sz = $urandom_range(0, 1) ? POS_HIGH : POS_LOW;
            end
            default: begin
                sx = POS_W'($urandom);
                sy = POS_W'($urandom);
                sz = POS_W'($urandom);
            end
        endcase
        case ($urandom_range(0, 7))
            0:       limit = '0;
            1:       limit = DIST_MAX;
            2:       limit = OUT_DIST_W'({$urandom, $urandom});
            default: limit = OUT_DIST_W'(longint'($urandom_range(1, 4)) << (2 * scale));
        endcase
        case ($urandom_range(0, 5))
            0:       count = '0;
            1:       count = SEL_W'($urandom_range(17, 31));
            2:       count = SEL_W'(MAX_EMIT);
            default: count = SEL_W'($urandom_range(1, 16));
        endcase
        set_search(sx, sy, sz, limit, count);

        // Under pressure the receiver stops while short batches keep coming.
        gapless = pressure || ($urandom_range(0, 3) == 0);
        if (pressure)
            hold_asks <= hold_asks + 1;
        sent     = 0;
        batch_no = 0;
        while (sent < budget) begin
            if (pressure)
                batch_len = $urandom_range(1, 4);
            else if ($urandom_range(0, 3) == 0)
                batch_len = $urandom_range(17, 40);
            else
                batch_len = $urandom_range(1, 16);
            for (int j = 0; j < batch_len; j++) begin
                pt = pick_point(scale);
                pt.batch_end = (j == batch_len - 1);
                offer_point(pt);
            end
            sent += batch_len;
            batch_no++;
            if (!pressure && (batch_no == 1 || $urandom_range(0, 5) == 0))
                drain_results();
        end
        drain_results();
    endtask

    // Main sequence and verdict.
    initial begin : stimulus
        int random_sent;
        int phase_sent;
        int phase_no;
        random_sent = 0;
        phase_no    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (random_sent < RANDOM_ITEMS) begin
            run_random_phase(PHASE_ITEMS, phase_no == 1, phase_sent);
            random_sent += phase_sent;
            phase_no++;
        end
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
